// ===== hdl/nspf_pkg.sv =====
// Shared types, constants and tables for the nearest scan point follower.
package nspf_pkg;
	localparam int RANGE_W = 17;
	localparam int ANGLE_W = 19;
	localparam int STEP_W = 18;
	localparam int GAIN_W = 16;
	localparam int CMD_W = 18;
	localparam int TRIG_STEPS_DEF = 16;
	localparam int TRIG_MAX = 24;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 19;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_START = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_LIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_ANG = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NEAR = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STOP = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CEIL = 3'd6;

	localparam logic signed [ANGLE_W-1:0] ANGLE_START_RST = -19'sd205887;
	localparam logic [STEP_W-1:0] ANGLE_STEP_RST = 18'd286;
	localparam logic [GAIN_W-1:0] GAIN_LIN_RST = 16'd6554;
	localparam logic [GAIN_W-1:0] GAIN_ANG_RST = 16'd26214;
	localparam logic [RANGE_W-1:0] NEAR_RST = 17'd205;
	localparam logic [RANGE_W-1:0] STOP_RST = 17'd410;
	localparam logic [RANGE_W-1:0] CEIL_RST = 17'd102400;

	localparam logic signed [20:0] ANG_PI = 21'sd205887;
	localparam logic signed [20:0] ANG_TWO_PI = 21'sd411775;
	localparam logic signed [20:0] ANG_HALF_PI = 21'sd102944;
	localparam logic [29:0] CORDIC_K = 30'd652032874;
	localparam logic signed [19:0] LIM19 = 20'sd262143;
	localparam int LIM17 = 131071;

	typedef struct packed {
		logic [RANGE_W-1:0] range;
		logic signed [ANGLE_W-1:0] angle;
	} scan_min_t;

	typedef struct packed {
		logic [RANGE_W-1:0] range_sample;
		logic last_sample;
	} in_item_t;

	typedef struct packed {
		logic [RANGE_W-1:0] linear_cmd;
		logic signed [CMD_W-1:0] angular_cmd;
		logic signed [CMD_W-1:0] target_x;
		logic signed [CMD_W-1:0] target_y;
		logic signed [ANGLE_W-1:0] target_angle;
		logic [RANGE_W-1:0] target_range;
	} out_item_t;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] angle_start;
		logic [STEP_W-1:0] angle_step;
		logic [GAIN_W-1:0] gain_linear;
		logic [GAIN_W-1:0] gain_angular;
		logic [RANGE_W-1:0] near_limit;
		logic [RANGE_W-1:0] stop_limit;
		logic [RANGE_W-1:0] search_ceiling;
	} cfg_t;

	function automatic logic signed [31:0] atan_q30(input logic [4:0] i);
		case (i)
			5'd0: atan_q30 = 32'sd843314857;
			5'd1: atan_q30 = 32'sd497837829;
			5'd2: atan_q30 = 32'sd263043836;
			5'd3: atan_q30 = 32'sd133525159;
			5'd4: atan_q30 = 32'sd67021687;
			5'd5: atan_q30 = 32'sd33543516;
			5'd6: atan_q30 = 32'sd16775851;
			5'd7: atan_q30 = 32'sd8388437;
			5'd8: atan_q30 = 32'sd4194283;
			5'd9: atan_q30 = 32'sd2097149;
			5'd10: atan_q30 = 32'sd1048576;
			5'd11: atan_q30 = 32'sd524288;
			5'd12: atan_q30 = 32'sd262144;
			5'd13: atan_q30 = 32'sd131072;
			5'd14: atan_q30 = 32'sd65536;
			5'd15: atan_q30 = 32'sd32768;
			5'd16: atan_q30 = 32'sd16384;
			5'd17: atan_q30 = 32'sd8192;
			5'd18: atan_q30 = 32'sd4096;
			5'd19: atan_q30 = 32'sd2048;
			5'd20: atan_q30 = 32'sd1024;
			5'd21: atan_q30 = 32'sd512;
			5'd22: atan_q30 = 32'sd256;
			5'd23: atan_q30 = 32'sd128;
			default: atan_q30 = 32'sd0;
		endcase
	endfunction
endpackage

// ===== hdl/nspf_stream_if.sv =====
// Valid/ready channel interfaces for items and configuration writes.
interface nspf_stream_if #(
	parameter int W = 1
);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface nspf_cfg_if;
	logic valid;
	logic ready;
	logic [nspf_pkg::CFG_IDX_W-1:0] index;
	logic [nspf_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/nspf_front.sv =====
// Front end: tracks the nearest sample of each scan, one sample per cycle while the queue is not full.
module nspf_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input nspf_pkg::in_item_t in_item,
	input nspf_pkg::cfg_t cfg,
	input logic q_full,
	output logic q_push,
	output nspf_pkg::scan_min_t q_item
);
	import nspf_pkg::*;

	logic scan_open_q;
	logic [RANGE_W-1:0] min_q;
	logic signed [ANGLE_W-1:0] best_q;
	logic signed [ANGLE_W-1:0] beam_q;
	logic [RANGE_W-1:0] cur_min;
	logic signed [ANGLE_W-1:0] cur_beam;
	logic take;
	logic [RANGE_W-1:0] new_min;
	logic signed [ANGLE_W-1:0] new_best;
	logic signed [19:0] beam_sum;
	logic signed [ANGLE_W-1:0] beam_next;

	assign in_ready = !q_full;
	assign take = in_valid && in_ready;
	assign cur_min = scan_open_q ? min_q : cfg.search_ceiling;
	assign cur_beam = scan_open_q ? beam_q : cfg.angle_start;
	assign new_min = (in_item.range_sample < cur_min) ? in_item.range_sample : cur_min;
	assign new_best = (in_item.range_sample < cur_min) ? cur_beam : best_q;
	assign beam_sum = 20'(cur_beam) + $signed({2'b00, cfg.angle_step});
	assign beam_next = (beam_sum > LIM19) ? ANGLE_W'(LIM19)
		: (beam_sum < -LIM19) ? ANGLE_W'(-LIM19) : ANGLE_W'(beam_sum);
	assign q_push = take && in_item.last_sample;
	assign q_item = '{range: new_min, angle: new_best};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_open_q <= 1'b0;
			best_q <= '0;
		end else if (take) begin
			scan_open_q <= !in_item.last_sample;
			best_q <= new_best;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			min_q <= new_min;
			beam_q <= beam_next;
		end
	end
endmodule

// ===== hdl/nspf_queue.sv =====
// Small FIFO between the scan front end and the trigonometry back end.
module nspf_queue #(
	parameter int DEPTH = nspf_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input nspf_pkg::scan_min_t push_item,
	output logic full,
	input logic pop,
	output logic empty,
	output nspf_pkg::scan_min_t pop_item
);
	import nspf_pkg::*;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	scan_min_t mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0] cnt_q;

	assign full = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign pop_item = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end
endmodule

// ===== hdl/nspf_back.sv =====
// Back end: CORDIC polar to Cartesian conversion and proportional commands.
module nspf_back #(
	parameter int TRIG_STEPS = nspf_pkg::TRIG_STEPS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic q_empty,
	output logic q_pop,
	input nspf_pkg::scan_min_t q_item,
	input nspf_pkg::cfg_t cfg,
	output logic out_valid,
	input logic out_ready,
	output nspf_pkg::out_item_t out_item
);
	import nspf_pkg::*;
	localparam int CW = $clog2(TRIG_STEPS + 1);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_ROT = 6'b000010,
		S_FIX = 6'b000100,
		S_MUL = 6'b001000,
		S_CMD = 6'b010000,
		S_OUT = 6'b100000
	} state_t;

	state_t st_q;
	logic [CW-1:0] i_q;
	logic signed [47:0] x_q, y_q;
	logic signed [36:0] z_q;
	logic flip_q;
	logic [RANGE_W-1:0] rng_q;
	logic signed [ANGLE_W-1:0] ang_q;
	logic signed [CMD_W-1:0] tx_q, ty_q;
	logic signed [35:0] plin_q, pang_q;
	logic signed [20:0] a0, a1;
	logic signed [20:0] ared;
	logic fl;
	logic signed [47:0] xs, ys;
	logic signed [47:0] xr, yr;
	logic signed [31:0] fx, fy;
	logic signed [CMD_W-1:0] cx, cy;
	logic signed [37:0] lr, ar;
	logic [RANGE_W-1:0] lin_c;
	logic signed [CMD_W-1:0] ang_c;

	function automatic logic signed [CMD_W-1:0] clip18(input logic signed [37:0] v);
		if (v > 38'sd131071) clip18 = 18'sd131071;
		else if (v < -38'sd131071) clip18 = -18'sd131071;
		else clip18 = v[CMD_W-1:0];
	endfunction

	always_comb begin
		a0 = 21'(q_item.angle);
		a1 = a0;
		if (a0 > ANG_PI) a1 = a0 - ANG_TWO_PI;
		else if (a0 < -ANG_PI) a1 = a0 + ANG_TWO_PI;
		ared = a1;
		fl = 1'b0;
		if (a1 > ANG_HALF_PI) begin
			ared = a1 - ANG_PI;
			fl = 1'b1;
		end else if (a1 < -ANG_HALF_PI) begin
			ared = a1 + ANG_PI;
			fl = 1'b1;
		end
	end

	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign xr = flip_q ? -x_q : x_q;
	assign yr = flip_q ? -y_q : y_q;
	assign fx = 32'((xr + 48'sd32768) >>> 16);
	assign fy = 32'((yr + 48'sd32768) >>> 16);
	assign cx = clip18(38'(fx));
	assign cy = clip18(38'(fy));
	assign lr = (38'(plin_q) + 38'sd32768) >>> 16;
	assign ar = (-38'(pang_q) + 38'sd32768) >>> 16;
	assign lin_c = (lr > 38'sd131071) ? RANGE_W'(LIM17) : RANGE_W'(lr);
	assign ang_c = clip18(ar);
	assign q_pop = (st_q == S_IDLE) && !q_empty;
	assign out_valid = (st_q == S_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			i_q <= '0;
		end else begin
			case (st_q)
				S_IDLE: if (!q_empty) begin
					st_q <= S_ROT;
					i_q <= '0;
				end
				S_ROT: if (i_q == CW'(TRIG_STEPS)) st_q <= S_FIX;
					else i_q <= i_q + 1'b1;
				S_FIX: st_q <= S_MUL;
				S_MUL: st_q <= S_CMD;
				S_CMD: st_q <= S_OUT;
				S_OUT: if (out_ready) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				rng_q <= q_item.range;
				ang_q <= q_item.angle;
				flip_q <= fl;
				x_q <= 48'($signed({1'b0, q_item.range}) * $signed({1'b0, CORDIC_K})) >>> 14;
				y_q <= '0;
				z_q <= 37'(ared) * 37'sd16384;
			end
			S_ROT: if (i_q != CW'(TRIG_STEPS)) begin
				if (z_q >= 0) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - 37'(atan_q30(5'(i_q)));
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + 37'(atan_q30(5'(i_q)));
				end
			end
			S_FIX: begin
				tx_q <= cx;
				ty_q <= cy;
			end
			S_MUL: begin
				plin_q <= 36'(tx_q) * $signed({1'b0, cfg.gain_linear});
				pang_q <= 36'(ty_q) * $signed({1'b0, cfg.gain_angular});
			end
			S_CMD: begin
				out_item.target_x <= tx_q;
				out_item.target_y <= ty_q;
				out_item.target_angle <= ang_q;
				out_item.target_range <= rng_q;
				if (tx_q > $signed({1'b0, cfg.near_limit})
						&& tx_q > $signed({1'b0, cfg.stop_limit})) begin
					out_item.linear_cmd <= lin_c;
					out_item.angular_cmd <= ang_c;
				end else begin
					out_item.linear_cmd <= '0;
					out_item.angular_cmd <= '0;
				end
			end
			default: ;
		endcase
	end
endmodule

// ===== hdl/nearest_scan_point_follower.sv =====
// Top level of the nearest scan point follower.
// Use: range samples enter on the sample channel, one per cycle, with
// last_sample set on the final beam of a scan. The front end keeps the
// smallest range below search_ceiling and its beam angle as samples stream.
// On the last sample the scan minimum is queued to the back end, which runs
// TRIG_STEPS CORDIC rotations on one shared rotator, then the gain
// multiplies, and presents one result on the result channel.
// Samples are accepted at one per cycle while the two-entry queue has room;
// the back end works on one scan at a time and pops the next scan minimum
// from the queue only once its result has been taken.
// When the receiver stalls the result holds, the queue fills, and then the
// sample channel drops ready. Reset clears the scan state, the best angle
// and the queue, and loads the register reset values. Configuration writes
// are always accepted and belong to idle times.
module nearest_scan_point_follower #(
	parameter int TRIG_STEPS = nspf_pkg::TRIG_STEPS_DEF
) (
	input logic clk,
	input logic arst_n,
	nspf_stream_if.sink samples,
	nspf_stream_if.source results,
	nspf_cfg_if.sink cfg_wr
);
	import nspf_pkg::*;

	cfg_t cfg_q;
	logic q_full, q_empty, q_push, q_pop;
	scan_min_t q_in, q_out;
	in_item_t in_item;
	out_item_t out_item;

	assign cfg_wr.ready = 1'b1;
	assign in_item = in_item_t'(samples.data);
	assign results.data = out_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{ANGLE_START_RST, ANGLE_STEP_RST, GAIN_LIN_RST, GAIN_ANG_RST,
				NEAR_RST, STOP_RST, CEIL_RST};
		end else if (cfg_wr.valid) begin
			case (cfg_wr.index)
				REG_ANGLE_START: cfg_q.angle_start <= cfg_wr.data;
				REG_ANGLE_STEP: cfg_q.angle_step <= cfg_wr.data[STEP_W-1:0];
				REG_GAIN_LIN: cfg_q.gain_linear <= cfg_wr.data[GAIN_W-1:0];
				REG_GAIN_ANG: cfg_q.gain_angular <= cfg_wr.data[GAIN_W-1:0];
				REG_NEAR: cfg_q.near_limit <= cfg_wr.data[RANGE_W-1:0];
				REG_STOP: cfg_q.stop_limit <= cfg_wr.data[RANGE_W-1:0];
				REG_CEIL: cfg_q.search_ceiling <= cfg_wr.data[RANGE_W-1:0];
				default: ;
			endcase
		end
	end

	nspf_front u_front (
		.clk, .arst_n,
		.in_valid(samples.valid), .in_ready(samples.ready), .in_item,
		.cfg(cfg_q), .q_full, .q_push, .q_item(q_in)
	);

	nspf_queue u_queue (
		.clk, .arst_n, .push(q_push), .push_item(q_in), .full(q_full),
		.pop(q_pop), .empty(q_empty), .pop_item(q_out)
	);

	nspf_back #(.TRIG_STEPS(TRIG_STEPS)) u_back (
		.clk, .arst_n, .q_empty, .q_pop, .q_item(q_out), .cfg(cfg_q),
		.out_valid(results.valid), .out_ready(results.ready), .out_item
	);
endmodule

// ===== hdl/nspf_checker.sv =====
// Port-level checks for the nearest scan point follower, bound to the top.
module nspf_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [106:0] out_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> !out_valid)
		else $error("results back to back");
	a_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data[106:90] != 17'd0 |-> !out_data[71] && out_data[71:54] != 18'd0)
		else $error("forward command with target not ahead");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		$past(in_ready) && !in_ready |-> $past(in_valid))
		else $error("ready dropped without traffic");
endmodule

bind nearest_scan_point_follower nspf_checker u_chk (
	.clk, .arst_n, .in_valid(samples.valid), .in_ready(samples.ready),
	.out_valid(results.valid), .out_ready(results.ready), .out_data(results.data)
);

// ===== tb/tb_nearest_scan_point_follower.sv =====
// Testbench for the nearest scan point follower: directed table, random scans, predictor check.
module tb_nearest_scan_point_follower;
	timeunit 1ns;
	timeprecision 1ps;
	import nspf_pkg::*;

	localparam int LAT = TRIG_STEPS_DEF + 10;
	localparam int N_RANDOM = 1100;
	localparam longint CYCLE_LIMIT = 400000;
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #5 clk = ~clk;

	nspf_stream_if #(.W($bits(in_item_t))) samples ();
	nspf_stream_if #(.W($bits(out_item_t))) results ();
	nspf_cfg_if cfg_wr ();

	nearest_scan_point_follower u_top (
		.clk(clk), .arst_n(arst_n), .samples(samples.sink),
		.results(results.source), .cfg_wr(cfg_wr.sink)
	);

	typedef struct {
		logic [RANGE_W-1:0] rng;
		logic last;
		logic known;
		out_item_t res;
	} row_t;

	// predictor state
	longint p_start, p_step, p_glin, p_gang, p_near, p_stop, p_ceil;
	longint p_min, p_best, p_beam;
	bit p_open;
	out_item_t follow_q[$];
	out_item_t pinned_q[$];
	bit pinned_v[$];

	int errors = 0;
	int n_in = 0, n_out = 0, n_scans_dir = 0;
	longint cycles = 0;
	bit stall_long = 0;
	bit no_idle = 0;

	task automatic report(input string what, input longint got, input longint want);
		errors++;
		$display("mismatch %s: got %0d expected %0d (t=%0t)", what, got, want, $realtime);
	endtask

	function automatic longint fshr(input longint v, input int s);
		if (v >= 0) return v >>> s;
		return -((-(v + 1)) >>> s) - 1;
	endfunction

	function automatic longint clip(input longint v, input longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	function automatic longint atan_tab(input int i);
		longint t[24] = '{843314857, 497837829, 263043836, 133525159, 67021687, 33543516,
			16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072, 65536,
			32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};
		return t[i];
	endfunction

	function automatic out_item_t follow_target(input longint r, input longint a0);
		out_item_t o;
		longint a, x, y, z, nx, px, py, lin, ang;
		bit flip;
		a = a0;
		flip = 0;
		if (a > 205887) a -= 411775;
		if (a < -205887) a += 411775;
		if (a > 102944) begin
			a -= 205887;
			flip = 1;
		end else if (a < -102944) begin
			a += 205887;
			flip = 1;
		end
		x = (r * 652032874) >>> 14;
		y = 0;
		z = a * 16384;
		for (int i = 0; i < TRIG_STEPS_DEF; i++) begin
			if (z >= 0) begin
				nx = x - fshr(y, i);
				y = y + fshr(x, i);
				z -= atan_tab(i);
			end else begin
				nx = x + fshr(y, i);
				y = y - fshr(x, i);
				z += atan_tab(i);
			end
			x = nx;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		px = clip(fshr(x + 32768, 16), LIM17);
		py = clip(fshr(y + 32768, 16), LIM17);
		lin = 0;
		ang = 0;
		if (px > p_near && px > p_stop) begin
			lin = clip((px * p_glin + 32768) >>> 16, LIM17);
			ang = clip(fshr(-(py * p_gang) + 32768, 16), LIM17);
		end
		o.linear_cmd = lin;
		o.angular_cmd = ang;
		o.target_x = px;
		o.target_y = py;
		o.target_angle = a0;
		o.target_range = r;
		return o;
	endfunction

	task automatic predict(input logic [RANGE_W-1:0] rng, input logic last);
		if (!p_open) begin
			p_min = p_ceil;
			p_beam = p_start;
			p_open = 1;
		end
		if (longint'(rng) < p_min) begin
			p_min = rng;
			p_best = p_beam;
		end
		p_beam = clip(p_beam + p_step, 262143);
		if (last) begin
			p_open = 0;
			follow_q.push_back(follow_target(p_min, p_best));
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint val);
		cfg_wr.valid <= 1'b1;
		cfg_wr.index <= idx;
		cfg_wr.data <= val[CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg_wr.ready);
		cfg_wr.valid <= 1'b0;
		case (idx)
			REG_ANGLE_START: p_start = longint'($signed(val[ANGLE_W-1:0]));
			REG_ANGLE_STEP: p_step = val[STEP_W-1:0];
			REG_GAIN_LIN: p_glin = val[GAIN_W-1:0];
			REG_GAIN_ANG: p_gang = val[GAIN_W-1:0];
			REG_NEAR: p_near = val[RANGE_W-1:0];
			REG_STOP: p_stop = val[RANGE_W-1:0];
			REG_CEIL: p_ceil = val[RANGE_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// valid stays high after an accept; idling or drain() drops it
	task automatic send(input logic [RANGE_W-1:0] rng, input logic last);
		in_item_t it;
		if (!no_idle) begin
			while ($urandom_range(99) < 12) begin
				samples.valid <= 1'b0;
				@(posedge clk);
			end
		end
		it.range_sample = rng;
		it.last_sample = last;
		samples.valid <= 1'b1;
		samples.data <= it;
		do @(posedge clk); while (!samples.ready);
		n_in++;
		predict(rng, last);
	endtask

	task automatic drain();
		samples.valid <= 1'b0;
		while (follow_q.size() != 0) @(posedge clk);
		repeat (LAT) @(posedge clk);
	endtask

	// random scan with some near obstacle and occasional noise
	task automatic random_scan(input int len);
		for (int i = 0; i < len; i++) begin
			logic [RANGE_W-1:0] r;
			case ($urandom_range(9))
				0: r = '1;
				1: r = $urandom_range(600);
				2: r = p_ceil;
				default: r = $urandom_range(131071);
			endcase
			send(r, i == len - 1);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && results.valid && results.ready) begin
			out_item_t got, want;
			got = results.data;
			n_out++;
			if (follow_q.size() == 0) begin
				report("unexpected result", got.target_range, -1);
			end else begin
				want = follow_q.pop_front();
				if (got.linear_cmd != want.linear_cmd)
					report("linear_cmd", got.linear_cmd, want.linear_cmd);
				if (got.angular_cmd != want.angular_cmd)
					report("angular_cmd", got.angular_cmd, want.angular_cmd);
				if (got.target_x != want.target_x)
					report("target_x", got.target_x, want.target_x);
				if (got.target_y != want.target_y)
					report("target_y", got.target_y, want.target_y);
				if (got.target_angle != want.target_angle)
					report("target_angle", got.target_angle, want.target_angle);
				if (got.target_range != want.target_range)
					report("target_range", got.target_range, want.target_range);
				if (pinned_q.size() != 0) begin
					if (pinned_v.pop_front()
							&& (got.target_range != pinned_q[0].target_range
							|| got.target_angle != pinned_q[0].target_angle))
						report("table result", got.target_range, pinned_q[0].target_range);
					void'(pinned_q.pop_front());
				end
			end
		end
	end

	// receiver: random stalls plus one long hold-off
	always @(posedge clk) begin
		cycles++;
		if (stall_long) results.ready <= 1'b0;
		else if (no_idle) results.ready <= 1'b1;
		else results.ready <= ($urandom_range(99) >= 12);
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("** nearest_scan_point_follower: FAILED **");
			$finish;
		end
	end

	initial begin
		row_t tab[$];
		row_t rw;
		out_item_t z;
		samples.valid = 1'b0;
		samples.data = '0;
		cfg_wr.valid = 1'b0;
		cfg_wr.index = '0;
		cfg_wr.data = '0;
		p_start = -205887; p_step = 286; p_glin = 6554; p_gang = 26214;
		p_near = 205; p_stop = 410; p_ceil = 102400;
		p_min = p_ceil; p_best = 0; p_beam = p_start; p_open = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; pinned: empty scan after reset gives the ceiling at angle 0
		z = '0;
		z.target_range = 17'd102400;
		tab.push_back('{17'h1ffff, 1'b1, 1'b1, z});
		tab.push_back('{17'd500, 1'b0, 1'b0, z});
		tab.push_back('{17'd500, 1'b0, 1'b0, z});
		tab.push_back('{17'd0, 1'b0, 1'b0, z});
		tab.push_back('{17'd0, 1'b1, 1'b0, z});
		tab.push_back('{17'd102400, 1'b1, 1'b0, z});
		tab.push_back('{17'd2000, 1'b0, 1'b0, z});
		tab.push_back('{17'd1000, 1'b0, 1'b0, z});
		tab.push_back('{17'd3000, 1'b1, 1'b0, z});
		tab.push_back('{17'd300, 1'b1, 1'b0, z});
		tab.push_back('{17'd131070, 1'b1, 1'b0, z});
		foreach (tab[i]) begin
			rw = tab[i];
			if (rw.last) begin
				pinned_q.push_back(rw.res);
				pinned_v.push_back(rw.known);
				n_scans_dir++;
			end
			send(rw.rng, rw.last);
		end
		drain();

		// extremes of the registers; long scan saturates beam angle
		write_reg(REG_ANGLE_START, 205887);
		write_reg(REG_ANGLE_STEP, 205887);
		write_reg(REG_GAIN_LIN, 65535);
		write_reg(REG_GAIN_ANG, 65535);
		write_reg(REG_NEAR, 0);
		write_reg(REG_STOP, 0);
		write_reg(REG_CEIL, 131071);
		write_reg(REG_NONE, 12345);
		for (int i = 0; i < 6; i++) send(17'd131071 - i, i == 5);
		send(17'd4000, 1'b1);
		drain();
		write_reg(REG_ANGLE_START, -205887);
		write_reg(REG_NEAR, 131071);
		write_reg(REG_STOP, 131071);
		write_reg(REG_CEIL, 0);
		random_scan(3);
		drain();

		// back pressure: receiver holds off while scans keep coming
		write_reg(REG_ANGLE_STEP, 0);
		write_reg(REG_NEAR, 205);
		write_reg(REG_STOP, 410);
		write_reg(REG_CEIL, 102400);
		fork
			begin
				stall_long = 1;
				repeat (200) @(posedge clk);
				stall_long = 0;
			end
			for (int i = 0; i < 12; i++) send($urandom_range(131071), 1'b1);
		join
		drain();

		// random phases with differing settings
		while (n_in < N_RANDOM - 50) begin
			write_reg(REG_ANGLE_START, $signed($urandom_range(411774)) - 205887);
			write_reg(REG_ANGLE_STEP, ($urandom_range(3) == 0) ? $urandom_range(205887)
				: $urandom_range(2000));
			write_reg(REG_GAIN_LIN, $urandom_range(65535));
			write_reg(REG_GAIN_ANG, $urandom_range(65535));
			write_reg(REG_NEAR, $urandom_range(2000));
			write_reg(REG_STOP, $urandom_range(2000));
			write_reg(REG_CEIL, ($urandom_range(4) == 0) ? $urandom_range(131071) : 131071);
			no_idle = ($urandom_range(4) == 0);
			for (int s = 0; s < 8; s++) random_scan($urandom_range(1, 24));
			drain();
			no_idle = 0;
		end
		drain();

		$display("covered %0d samples, %0d results, %0d directed scans", n_in, n_out,
			n_scans_dir);
		$display("register extremes, empty scans, ties, saturated angles, long back pressure");
		if (errors == 0 && follow_q.size() == 0) begin
			$display("** nearest_scan_point_follower: PASSED **");
		end else begin
			$display("** nearest_scan_point_follower: FAILED **");
		end
		$finish;
	end
endmodule
